/* hdl/pirl_pkg.sv */
// ----------------------------------------------------------------------------
// pirl_pkg: shared types and constants for the positional insert/remove list
// Request kinds, result status codes, field widths and the cell control word.
// ----------------------------------------------------------------------------
package pirl_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Default list capacity (entries)
    localparam int DEF_CAPACITY = 16;

    // Request kind, carried on the slave-side tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // Result status, carried on the master-side tuser
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic ins;   // open a slot at the position, shift upper cells up
        logic rem;   // close the slot at the position, shift upper cells down
    } t_cell_ctrl;

endpackage

/* hdl/positional_insert_remove_list_top.sv */
// ----------------------------------------------------------------------------
// positional_insert_remove_list_top: fixed-capacity list of 64-bit words
// Append, insert, remove or read at a position over a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: kind; tdata: position, value
//  m_axis    | out       | tuser: status; tdata: data_out, length_after
//
//  One request per cycle: every cell shifts at once, so an insert or remove
//  completes in the cycle of the transfer and its result is captured in the
//  output register at the same clock edge. The output register is the only
//  stall point; a new request is taken whenever it is empty or being drained.
//  Reset clears the length and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_top
    import pirl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // [4:0] position, [68:5] value, [71:69] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [63:0] data_out, [68:64] length_after, [71:69] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request fields
    t_kind             w_kind;
    logic [POS_W-1:0]  w_pos_in;
    logic [DATA_W-1:0] w_value;
    logic              w_accept;

    assign w_kind   = t_kind'(i_s_axis_tuser);
    assign w_pos_in = i_s_axis_tdata[POS_W-1:0];
    assign w_value  = i_s_axis_tdata[POS_W +: DATA_W];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Length and output registers
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] n_out_data;
    logic [LEN_W-1:0]  r_out_len;

    // Decode
    logic [IDX_W-1:0]  w_count_x;
    logic [IDX_W-1:0]  w_pos;
    logic              w_is_ins;
    logic              w_full;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_rd_data;

    assign w_count_x = IDX_W'(r_count);
    assign w_is_ins  = (w_kind == KIND_APPEND) || (w_kind == KIND_INSERT);
    assign w_pos     = (w_kind == KIND_APPEND) ? w_count_x : IDX_W'(w_pos_in);
    assign w_full    = (r_count >= CNT_W'(CAPACITY));

    // Command, status and next length
    always_comb begin
        w_ctrl     = '0;
        n_status   = STATUS_OK;
        n_out_data = '0;
        n_count    = r_count;
        if (w_is_ins) begin
            if (w_pos > w_count_x) begin
                n_status = STATUS_RANGE;
            end else if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                w_ctrl.ins = w_accept;
                if (w_accept) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end else begin
            if (w_pos >= w_count_x) begin
                n_status = STATUS_RANGE;
            end else begin
                n_out_data = w_rd_data;
                if (w_kind == KIND_REMOVE) begin
                    w_ctrl.rem = w_accept;
                    if (w_accept) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
        end
    end

    // Row of cells
    logic [DATA_W-1:0] w_cell_data [CAPACITY];
    logic [DATA_W-1:0] w_cell_tap  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_lower;
        logic [DATA_W-1:0] w_upper;
        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_cell_data[g+1];
        end
        pirl_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_pos),
            .i_value (w_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_cell_data[g]),
            .o_tap   (w_cell_tap[g])
        );
    end

    // Read bus: only the selected cell drives a non-zero tap
    always_comb begin
        w_rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_data = w_rd_data | w_cell_tap[i];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_out_data <= n_out_data;
            r_out_len  <= LEN_W'(n_count);
        end
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_len, r_out_data};
    assign o_m_axis_tuser  = r_status;

endmodule

/* hdl/pirl_cell.sv */
// ----------------------------------------------------------------------------
// pirl_cell: one storage cell of the list row
// Holds one entry; takes its lower neighbour, upper neighbour or the new
// value according to the broadcast command, and offers its word on the read
// bus when the position selects it.
// ----------------------------------------------------------------------------
module pirl_cell
    import pirl_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = POS_W
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_pos,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_lower,   // word of the cell below
    input  logic [DATA_W-1:0] i_upper,   // word of the cell above
    output logic [DATA_W-1:0] o_data,    // held word
    output logic [DATA_W-1:0] o_tap      // held word when selected, else zero
);

    localparam logic [IDX_W-1:0] L_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_at_pos;
    logic              w_above_pos;

    assign w_at_pos    = (i_pos == L_IDX);
    assign w_above_pos = (L_IDX > i_pos);

    // Next word: shift up, take the new value, shift down or hold
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (w_above_pos) begin
                n_data = i_lower;
            end else if (w_at_pos) begin
                n_data = i_value;
            end
        end else if (i_ctrl.rem) begin
            if (w_at_pos || w_above_pos) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_at_pos ? r_data : '0;

endmodule

/* hdl/pirl_chk.sv */
// ----------------------------------------------------------------------------
// pirl_chk: port-level checks for the positional insert/remove list
// Watches the result stream and the reset behaviour of the top level.
// ----------------------------------------------------------------------------
module pirl_chk
    import pirl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    localparam int LEN_CAP = (CAPACITY < 32) ? CAPACITY : 31;

    // Reset empties the result register
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Status is always a defined code
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == STATUS_OK ||
                             o_m_axis_tuser == STATUS_RANGE ||
                             o_m_axis_tuser == STATUS_FULL))
        else $error("undefined status code");

    // A failed request returns no data
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != STATUS_OK) |->
            (o_m_axis_tdata[63:0] == 64'd0))
        else $error("data returned with an error status");

    // Length never exceeds the capacity
    a_len_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && CAPACITY < 32) |->
            (o_m_axis_tdata[68:64] <= 5'(LEN_CAP)))
        else $error("length beyond capacity");

    // A stalled result holds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind positional_insert_remove_list_top pirl_chk #(.CAPACITY(CAPACITY)) u_pirl_chk (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_insert_remove_list_top
// Drives append, insert, remove and read requests over the request stream,
// keeps its own copy of the list to predict each result, and compares every
// result transfer field by field. A directed opening covers the empty list,
// the full list and every out-of-range case. Random traffic then follows,
// with idling on both streams and a pause that drains the block completely.
// ----------------------------------------------------------------------------
module tb;
    import pirl_pkg::*;

    localparam int LIST_DEPTH  = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS_PER_PHASE = 150;

    // Expected outcome of one request
    typedef struct {
        t_status     status;
        logic [63:0] word;
        logic [4:0]  length;
    } t_list_result;

    // Shadow list and queue of outcomes still to arrive
    class list_scoreboard;
        logic [63:0]  list_words [LIST_DEPTH];
        int           list_len;
        t_list_result pending_results [$];
        int           error_count;
        int           results_checked;
        int           kind_seen [4];
        int           status_seen [3];

        function new();
            list_len        = 0;
            error_count     = 0;
            results_checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        // Apply an accepted request to the shadow list and queue its outcome
        function void note_request(t_kind kind, logic [4:0] pos, logic [63:0] value);
            t_list_result outcome;
            int           slot;
            int           idx;
            outcome.status = STATUS_OK;
            outcome.word   = '0;
            slot           = int'(pos);
            kind_seen[kind]++;
            if (kind == KIND_APPEND) begin
                slot = list_len;
            end
            if (kind == KIND_APPEND || kind == KIND_INSERT) begin
                // position check comes before the full check
                if (slot > list_len) begin
                    outcome.status = STATUS_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    outcome.status = STATUS_FULL;
                end else begin
                    for (idx = list_len; idx > slot; idx--)
                        list_words[idx] = list_words[idx-1];
                    list_words[slot] = value;
                    list_len++;
                end
            end else if (slot >= list_len) begin
                outcome.status = STATUS_RANGE;
            end else begin
                outcome.word = list_words[slot];
                if (kind == KIND_REMOVE) begin
                    for (idx = slot; idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx+1];
                    list_len--;
                end
            end
            outcome.length = 5'(list_len);
            pending_results.push_back(outcome);
        endfunction

        // Compare one result transfer with the oldest outcome
        function void check_result(logic [1:0] status, logic [63:0] word, logic [4:0] length);
            t_list_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d, data %h, length %0d",
                         $time, status, word, length);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (int'(want.status) < 3) status_seen[want.status]++;
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, status);
                error_count++;
            end
            if (word !== want.word) begin
                $display("%0t: data mismatch: expected %h, got %h", $time, want.word, word);
                error_count++;
            end
            if (length !== want.length) begin
                $display("%0t: length mismatch: expected %0d, got %0d",
                         $time, want.length, length);
                error_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // [4:0] position, [68:5] value, [71:69] zero
    logic [1:0]  s_tuser = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [63:0] data_out, [68:64] length_after, [71:69] zero
    logic [1:0]  m_tuser;        // [1:0] status

    int send_idle = 0;   // percentage of cycles the sender holds back
    int recv_idle = 0;   // percentage of cycles the receiver stalls
    int cycle_count = 0;

    list_scoreboard sb = new();

    positional_insert_remove_list_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[63:0], m_tdata[68:64]);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, sb.pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request and hold it until the transfer; called at a clock edge
    task automatic send_request(t_kind kind, logic [4:0] pos, logic [63:0] value);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, value, pos};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(kind, pos, value);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Directed opening: empty list, fill to capacity, full and range cases
    task automatic run_directed();
        int n;
        send_request(KIND_READ,   5'd0,  '1);
        send_request(KIND_REMOVE, 5'd0,  '1);
        send_request(KIND_INSERT, 5'd1,  64'h0123_4567_89AB_CDEF);
        send_request(KIND_READ,   5'd31, '0);
        send_request(KIND_INSERT, 5'd0,  '1);
        send_request(KIND_APPEND, 5'd31, '0);                     // position ignored
        send_request(KIND_INSERT, 5'd1,  64'hAAAA_AAAA_AAAA_AAAA); // into the middle
        send_request(KIND_READ,   5'd1,  '1);
        for (n = 0; n < LIST_DEPTH - 3; n++)
            send_request(KIND_APPEND, 5'($urandom_range(0, 31)),
                         (n == 0) ? 64'h5555_5555_5555_5555 : {$urandom(), $urandom()});
        // list is full here
        send_request(KIND_APPEND, 5'd0,  64'h8000_0000_0000_0001);
        send_request(KIND_INSERT, 5'd4,  '1);
        send_request(KIND_INSERT, 5'd17, '1);   // bad position beats full
        send_request(KIND_INSERT, 5'd16, '1);   // position at the end, still full
        send_request(KIND_READ,   5'd15, '0);
        send_request(KIND_READ,   5'd16, '0);
        send_request(KIND_REMOVE, 5'd15, '0);   // last entry
        send_request(KIND_REMOVE, 5'd0,  '0);   // first entry
        send_request(KIND_INSERT, 5'd14, 64'hDEAD_BEEF_0000_FFFF); // at the end
    endtask

    // Random traffic biased to keep the list between empty and full
    task automatic run_random(int n_items, bit drain_midway);
        int          n;
        int          len;
        int          grow;
        t_kind       kind;
        logic [4:0]  pos;
        for (n = 0; n < n_items; n++) begin
            if (drain_midway && n == n_items / 2) begin
                wait_drained();
                repeat ($urandom_range(3, 20)) @(posedge i_clk);
            end
            len  = sb.list_len;
            grow = (len < 4) ? 65 : ((len > 12) ? 30 : 48);
            if ($urandom_range(0, 99) < grow)
                kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
            else
                kind = $urandom_range(0, 1) ? KIND_REMOVE : KIND_READ;
            if ($urandom_range(0, 99) < 12)
                pos = 5'($urandom_range(0, 31));
            else if (kind == KIND_APPEND || kind == KIND_INSERT)
                pos = 5'($urandom_range(0, len));
            else
                pos = (len == 0) ? 5'd0 : 5'($urandom_range(0, len - 1));
            send_request(kind, pos, random_word());
        end
    endtask

    // Main sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 30;
        recv_idle = 53;
        run_directed();
        run_random(RANDOM_ITEMS_PER_PHASE, 1'b1);

        send_idle = 53;
        recv_idle = 30;
        run_random(RANDOM_ITEMS_PER_PHASE, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_ITEMS_PER_PHASE, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Requests: %0d append, %0d insert, %0d remove, %0d read; %0d results checked",
                 sb.kind_seen[KIND_APPEND], sb.kind_seen[KIND_INSERT],
                 sb.kind_seen[KIND_REMOVE], sb.kind_seen[KIND_READ], sb.results_checked);
        $display("Outcomes: %0d ok, %0d out of range, %0d list full",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_RANGE],
                 sb.status_seen[STATUS_FULL]);
        if (sb.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
